// ----- rtl/core/rmq_pkg.sv -----
`default_nettype none

package rmq_pkg;

    localparam int ONE_Q14 = 16384;

    // square root of a 32-bit word, one result bit per stage
    localparam int SQRT_STAGES = 16;
    localparam int SQRT_IN_W = 2 * SQRT_STAGES;
    localparam int ROOT_W = SQRT_STAGES;
    localparam int SQ_REM_W = ROOT_W + 2;

    // numerator |d| * 8192 + r/2, quotient bits per stage
    localparam int DIV_NUM_W = 30;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES = DIV_NUM_W / DIV_PER_STAGE;

    localparam int DIFF_W = 18;
    localparam int WIDE_W = 19;
    localparam int RAD_W = 17;

    typedef logic [1:0] branch_t;
    localparam branch_t BR_TRACE = 2'd0;
    localparam branch_t BR_X = 2'd1;
    localparam branch_t BR_Y = 2'd2;
    localparam branch_t BR_Z = 2'd3;

    typedef struct packed {
        logic signed [15:0] m_r0c0;
        logic signed [15:0] m_r0c1;
        logic signed [15:0] m_r0c2;
        logic signed [15:0] m_r1c0;
        logic signed [15:0] m_r1c1;
        logic signed [15:0] m_r1c2;
        logic signed [15:0] m_r2c0;
        logic signed [15:0] m_r2c1;
        logic signed [15:0] m_r2c2;
    } mat_t;

    typedef struct packed {
        logic signed [15:0] q_w;
        logic signed [15:0] q_x;
        logic signed [15:0] q_y;
        logic signed [15:0] q_z;
        logic               degenerate;
    } quat_t;

    // what travels beside the arithmetic through the pipeline
    typedef struct packed {
        logic                          degen;
        branch_t                       branch;
        logic [3:0]                    neg;
        logic [ROOT_W-1:0]             root;
        logic [3:0][DIFF_W-1:0]        d;
    } side_t;

endpackage

`default_nettype wire

// ----- rtl/core/rmq_div_lane.sv -----
`default_nettype none

module rmq_div_lane (
    input  wire                           aclk,
    input  wire                           en,
    input  wire [rmq_pkg::DIV_NUM_W-1:0]  num,
    input  wire [rmq_pkg::ROOT_W-1:0]     den,
    output logic [rmq_pkg::DIV_NUM_W-1:0] quo
);

    localparam int S = rmq_pkg::DIV_STAGES;
    localparam int NW = rmq_pkg::DIV_NUM_W;
    localparam int RW = rmq_pkg::ROOT_W;

    logic [RW-1:0] st_rem [0:S];
    logic [NW-1:0] st_num [0:S];
    logic [NW-1:0] st_quo [0:S];
    logic [RW-1:0] st_den [0:S];

    logic [RW-1:0] rem_reg [1:S];
    logic [NW-1:0] num_reg [1:S];
    logic [NW-1:0] quo_reg [1:S];
    logic [RW-1:0] den_reg [1:S];

    assign st_rem[0] = '0;
    assign st_num[0] = num;
    assign st_quo[0] = '0;
    assign st_den[0] = den;

    genvar s;
    generate
        for (s = 0; s < S; s++) begin : g_stage
            logic [RW-1:0] rem_next;
            logic [NW-1:0] num_next;
            logic [NW-1:0] quo_next;

            always_comb begin
                logic [RW:0] t;
                rem_next = st_rem[s];
                num_next = st_num[s];
                quo_next = st_quo[s];
                for (int b = 0; b < rmq_pkg::DIV_PER_STAGE; b++) begin
                    t = {rem_next, num_next[NW-1]};
                    num_next = {num_next[NW-2:0], 1'b0};
                    if (t >= {1'b0, st_den[s]}) begin
                        t = t - {1'b0, st_den[s]};
                        quo_next = {quo_next[NW-2:0], 1'b1};
                    end else begin
                        quo_next = {quo_next[NW-2:0], 1'b0};
                    end
                    rem_next = t[RW-1:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s+1] <= rem_next;
                    num_reg[s+1] <= num_next;
                    quo_reg[s+1] <= quo_next;
                    den_reg[s+1] <= st_den[s];
                end
            end

            assign st_rem[s+1] = rem_reg[s+1];
            assign st_num[s+1] = num_reg[s+1];
            assign st_quo[s+1] = quo_reg[s+1];
            assign st_den[s+1] = den_reg[s+1];
        end
    endgenerate

    assign quo = st_quo[S];

endmodule

`default_nettype wire

// ----- rtl/core/rotation_matrix_to_quaternion_unit.sv -----
`default_nettype none

// Rotation matrix (nine signed Q2.14 entries) to unit quaternion (w,x,y,z) in
// Q2.14 by Shepperd's method. One matrix is taken every cycle while the output
// is not stalled. Each passes the 16-stage square root (one root bit a stage)
// and the 15-stage dividers (two quotient bits a stage, one lane per component).
// The whole pipeline holds while a finished result is not taken. A non-positive
// radicand gives degenerate = 1 and all-zero components.
module rotation_matrix_to_quaternion_unit (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire rmq_pkg::mat_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output rmq_pkg::quat_t       m_data
);

    localparam int SQ = rmq_pkg::SQRT_STAGES;
    localparam int DS = rmq_pkg::DIV_STAGES;
    localparam int RW = rmq_pkg::ROOT_W;
    localparam int QW = rmq_pkg::SQ_REM_W;
    localparam int IW = rmq_pkg::SQRT_IN_W;
    localparam int NW = rmq_pkg::DIV_NUM_W;
    localparam int DW = rmq_pkg::DIFF_W;
    localparam int WW = rmq_pkg::WIDE_W;

    logic adv;
    assign adv = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- input register
    rmq_pkg::mat_t in_reg;
    logic          in_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg <= s_data;
        end
    end

    // ---------------- branch choice, radicand, numerators
    logic signed [WW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [WW-1:0] tr, rad;
    rmq_pkg::side_t       sb_first;
    logic [IW-1:0]        sq_in;

    assign a00 = WW'(in_reg.m_r0c0);
    assign a01 = WW'(in_reg.m_r0c1);
    assign a02 = WW'(in_reg.m_r0c2);
    assign a10 = WW'(in_reg.m_r1c0);
    assign a11 = WW'(in_reg.m_r1c1);
    assign a12 = WW'(in_reg.m_r1c2);
    assign a20 = WW'(in_reg.m_r2c0);
    assign a21 = WW'(in_reg.m_r2c1);
    assign a22 = WW'(in_reg.m_r2c2);
    assign tr = a00 + a11 + a22;

    always_comb begin
        sb_first = '0;
        if (tr > 0) begin
            sb_first.branch = rmq_pkg::BR_TRACE;
            rad = WW'(rmq_pkg::ONE_Q14) + tr;
            sb_first.d[1] = DW'(a21 - a12);
            sb_first.d[2] = DW'(a02 - a20);
            sb_first.d[3] = DW'(a10 - a01);
        end else if (a00 > a11 && a00 > a22) begin
            sb_first.branch = rmq_pkg::BR_X;
            rad = WW'(rmq_pkg::ONE_Q14) + a00 - a11 - a22;
            sb_first.d[0] = DW'(a21 - a12);
            sb_first.d[2] = DW'(a01 + a10);
            sb_first.d[3] = DW'(a02 + a20);
        end else if (a11 > a22) begin
            sb_first.branch = rmq_pkg::BR_Y;
            rad = WW'(rmq_pkg::ONE_Q14) + a11 - a00 - a22;
            sb_first.d[0] = DW'(a02 - a20);
            sb_first.d[1] = DW'(a01 + a10);
            sb_first.d[3] = DW'(a12 + a21);
        end else begin
            sb_first.branch = rmq_pkg::BR_Z;
            rad = WW'(rmq_pkg::ONE_Q14) + a22 - a00 - a11;
            sb_first.d[0] = DW'(a10 - a01);
            sb_first.d[1] = DW'(a02 + a20);
            sb_first.d[2] = DW'(a12 + a21);
        end
        sb_first.degen = (rad <= 0);
        // radicand in Q28 so that the root comes out in Q14
        if (sb_first.degen) begin
            sq_in = '0;
        end else begin
            sq_in = {1'b0, rad[rmq_pkg::RAD_W-1:0], 14'b0};
        end
    end

    // ---------------- square root pipeline
    logic [QW-1:0]   sq_rem_reg  [0:SQ];
    logic [RW-1:0]   sq_root_reg [0:SQ];
    logic [IW-1:0]   sq_rest_reg [0:SQ];
    rmq_pkg::side_t  sq_sb_reg   [0:SQ];
    logic            sq_vld_reg  [0:SQ];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_vld_reg[0] <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rest_reg[0] <= sq_in;
            sq_sb_reg[0]   <= sb_first;
        end
    end

    genvar j;
    generate
        for (j = 0; j < SQ; j++) begin : g_sqrt
            logic [QW+1:0] shifted;
            logic [QW+1:0] trial;
            logic          bit_ok;

            assign shifted = {sq_rem_reg[j], sq_rest_reg[j][IW-1:IW-2]};
            assign trial = shifted - {2'b0, sq_root_reg[j], 2'b01};
            assign bit_ok = (shifted >= {2'b0, sq_root_reg[j], 2'b01});

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sq_vld_reg[j+1] <= 1'b0;
                end else if (adv) begin
                    sq_vld_reg[j+1] <= sq_vld_reg[j];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    sq_rem_reg[j+1]  <= bit_ok ? trial[QW-1:0] : shifted[QW-1:0];
                    sq_root_reg[j+1] <= {sq_root_reg[j][RW-2:0], bit_ok};
                    sq_rest_reg[j+1] <= {sq_rest_reg[j][IW-3:0], 2'b00};
                    sq_sb_reg[j+1]   <= sq_sb_reg[j];
                end
            end
        end
    endgenerate

    // ---------------- numerators |d| * 8192 + r/2
    logic [3:0][NW-1:0] nm_num_reg;
    rmq_pkg::side_t     nm_sb_reg;
    logic               nm_vld_reg;
    logic [3:0][NW-1:0] nm_num_next;
    rmq_pkg::side_t     nm_sb_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nm_vld_reg <= 1'b0;
        end else if (adv) begin
            nm_vld_reg <= sq_vld_reg[SQ];
        end
    end

    always_comb begin
        logic [DW-1:0] mag;
        nm_sb_next      = sq_sb_reg[SQ];
        nm_sb_next.root = sq_root_reg[SQ];
        for (int k = 0; k < 4; k++) begin
            mag = sq_sb_reg[SQ].d[k][DW-1] ? (~sq_sb_reg[SQ].d[k] + 1'b1)
                                            : sq_sb_reg[SQ].d[k];
            nm_sb_next.neg[k] = sq_sb_reg[SQ].d[k][DW-1];
            nm_num_next[k] = {mag[DW-2:0], 13'b0} + NW'(sq_root_reg[SQ][RW-1:1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nm_sb_reg  <= nm_sb_next;
            nm_num_reg <= nm_num_next;
        end
    end

    // ---------------- divider lanes with matching side line
    logic [NW-1:0]  quo [0:3];
    rmq_pkg::side_t dv_sb_reg [0:DS-1];
    logic [DS-1:0]  dv_vld_reg;

    genvar k;
    generate
        for (k = 0; k < 4; k++) begin : g_lane
            rmq_div_lane u_lane (
                .aclk (aclk),
                .en   (adv),
                .num  (nm_num_reg[k]),
                .den  (nm_sb_reg.root),
                .quo  (quo[k])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg <= '0;
        end else if (adv) begin
            dv_vld_reg <= {dv_vld_reg[DS-2:0], nm_vld_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_sb_reg[0] <= nm_sb_reg;
            for (int i = 1; i < DS; i++) begin
                dv_sb_reg[i] <= dv_sb_reg[i-1];
            end
        end
    end

    // ---------------- saturate, place the big component, output register
    rmq_pkg::side_t     sb_last;
    logic [3:0][15:0]   comp;
    logic [RW-1:0]      big;
    rmq_pkg::quat_t     m_data_next;

    assign sb_last = dv_sb_reg[DS-1];
    assign big = RW'(({1'b0, sb_last.root} + 1'b1) >> 1);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (sb_last.branch == i[1:0]) begin
                comp[i] = big;
            end else if (!sb_last.neg[i]) begin
                comp[i] = (quo[i] > NW'(32767)) ? 16'h7FFF : quo[i][15:0];
            end else begin
                comp[i] = (quo[i] > NW'(32768)) ? 16'h8000 : (~quo[i][15:0] + 1'b1);
            end
            if (sb_last.degen) begin
                comp[i] = '0;
            end
        end
        m_data_next.q_w = comp[0];
        m_data_next.q_x = comp[1];
        m_data_next.q_y = comp[2];
        m_data_next.q_z = comp[3];
        m_data_next.degenerate = sb_last.degen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (adv) begin
            m_valid <= dv_vld_reg[DS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.q_w == 0 && m_data.q_x == 0 && m_data.q_y == 0 && m_data.q_z == 0)
        else $error("degenerate result with non-zero components");

    a_root_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_vld_reg[SQ] && !sq_sb_reg[SQ].degen |-> sq_root_reg[SQ] >= RW'(128))
        else $error("square root below the least positive radicand");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data) && $stable(nm_num_reg))
        else $error("pipeline moved while output stalled");
`endif

endmodule

`default_nettype wire
